[rtl/dfe_pkg.sv]
// ----------------------------------------------------------------------------
// dfe_pkg
// Shared types and constants for the delimiter frame extractor.
// ----------------------------------------------------------------------------
package dfe_pkg;

   // Body length limit; the byte count saturates here.
   localparam int FRAME_BYTES = 2048;

   localparam int BYTE_W = 8;
   localparam int POS_W  = 12;
   localparam int CNT_W  = $clog2(FRAME_BYTES + 1);

   // Result queue
   localparam int FIFO_DEPTH = 4;
   localparam int PTR_W      = $clog2(FIFO_DEPTH);
   localparam int LVL_W      = $clog2(FIFO_DEPTH + 1);

   // Configuration register indexes
   localparam int            CSR_IDX_W   = 2;
   localparam logic [CSR_IDX_W-1:0] CSR_LEAD  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_START = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_STOP  = 2'd2;

   // Register reset values: '!', '&', '#'
   localparam logic [BYTE_W-1:0] LEAD_RESET  = 8'h21;
   localparam logic [BYTE_W-1:0] START_RESET = 8'h26;
   localparam logic [BYTE_W-1:0] STOP_RESET  = 8'h23;

   typedef struct packed {
      logic [BYTE_W-1:0] out_byte;
      logic              frame_end;
      logic [POS_W-1:0]  position;
      logic              overflowed;
   } dfe_result_type;

   // Up to two results produced by one input transaction
   typedef struct packed {
      logic [1:0]     count;
      dfe_result_type first;
      dfe_result_type second;
   } dfe_push_type;

   // Low POS_W bits of a count, zero-extended when the count is narrower
   function automatic logic [POS_W-1:0] pos_of(input logic [CNT_W-1:0] c);
      logic [CNT_W+POS_W-1:0] w;
      w = (CNT_W + POS_W)'(c);
      return w[POS_W-1:0];
   endfunction

endpackage

[rtl/dfe_core.sv]
// ----------------------------------------------------------------------------
// dfe_core
// Deframing state machine: configuration registers, phase, body count and
// overflow flag; turns one registered byte into zero, one or two results.
// ----------------------------------------------------------------------------
module dfe_core import dfe_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 csr_we,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [BYTE_W-1:0]    csr_wdata,
   input  logic                 fire,
   input  logic [BYTE_W-1:0]    rx_byte,
   output dfe_push_type         push
);

   typedef enum logic [1:0] {
      PH_HUNT,
      PH_START,
      PH_BODY,
      PH_HELD
   } phase_type;

   localparam logic [CNT_W-1:0] FrameMax = CNT_W'(FRAME_BYTES);

   phase_type          phase_ff, phase_in;
   logic [CNT_W-1:0]   count_ff, count_in;
   logic               ovf_ff, ovf_in;
   logic [BYTE_W-1:0]  lead_ff, start_ff, stop_ff;

   logic [CNT_W-1:0]   c1;
   logic               ok0, ok1;

   function automatic dfe_result_type body(input logic [BYTE_W-1:0] b,
                                           input logic [CNT_W-1:0] c);
      dfe_result_type r;
      r.out_byte   = b;
      r.frame_end  = 1'b0;
      r.position   = pos_of(c);
      r.overflowed = 1'b0;
      return r;
   endfunction

   // room checks for the held lead and the byte after it
   assign ok0 = count_ff < FrameMax;
   assign c1  = ok0 ? count_ff + CNT_W'(1) : count_ff;
   assign ok1 = c1 < FrameMax;

   always_comb begin
      phase_in = phase_ff;
      count_in = count_ff;
      ovf_in   = ovf_ff;
      push     = '0;
      if (fire) begin
         unique case (phase_ff)
            PH_HUNT: begin
               if (rx_byte == lead_ff) phase_in = PH_START;
            end
            PH_START: begin
               // a wrong byte keeps waiting for the start character
               if (rx_byte == start_ff) begin
                  phase_in = PH_BODY;
                  count_in = '0;
                  ovf_in   = 1'b0;
               end
            end
            PH_BODY: begin
               if (rx_byte == lead_ff) begin
                  phase_in = PH_HELD;
               end else if (ok0) begin
                  push.count = 2'd1;
                  push.first = body(rx_byte, count_ff);
                  count_in   = c1;
               end else begin
                  ovf_in = 1'b1;
               end
            end
            PH_HELD: begin
               // stop test first, so lead equal to stop ends the frame
               if (rx_byte == stop_ff) begin
                  push.count            = 2'd1;
                  push.first.out_byte   = '0;
                  push.first.frame_end  = 1'b1;
                  push.first.position   = pos_of(count_ff);
                  push.first.overflowed = ovf_ff;
                  phase_in = PH_HUNT;
                  count_in = '0;
                  ovf_in   = 1'b0;
               end else begin
                  if (ok0) begin
                     push.count = 2'd1;
                     push.first = body(lead_ff, count_ff);
                  end else begin
                     ovf_in = 1'b1;
                  end
                  count_in = c1;
                  if (rx_byte != lead_ff) begin
                     phase_in = PH_BODY;
                     if (ok1) begin
                        push.count  = 2'd2;
                        push.second = body(rx_byte, c1);
                        count_in    = c1 + CNT_W'(1);
                     end else begin
                        ovf_in = 1'b1;
                     end
                  end
               end
            end
            default: phase_in = PH_HUNT;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_HUNT;
         count_ff <= '0;
         ovf_ff   <= 1'b0;
         lead_ff  <= LEAD_RESET;
         start_ff <= START_RESET;
         stop_ff  <= STOP_RESET;
      end else begin
         phase_ff <= phase_in;
         count_ff <= count_in;
         ovf_ff   <= ovf_in;
         if (csr_we) begin
            unique case (csr_index)
               CSR_LEAD:  lead_ff  <= csr_wdata;
               CSR_START: start_ff <= csr_wdata;
               CSR_STOP:  stop_ff  <= csr_wdata;
               default: ;
            endcase
         end
      end
   end

endmodule

[rtl/dfe_fifo.sv]
// ----------------------------------------------------------------------------
// dfe_fifo
// Small result queue: takes up to two results per cycle, gives one.
// ----------------------------------------------------------------------------
module dfe_fifo import dfe_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  dfe_push_type     push,
   output logic             out_valid,
   input  logic             out_ready,
   output dfe_result_type   out_data,
   output logic [LVL_W-1:0] level
);

   dfe_result_type   mem_ff [FIFO_DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [LVL_W-1:0] level_ff, level_in;
   logic             pop;

   assign out_valid = level_ff != '0;
   assign out_data  = mem_ff[rd_ptr_ff];
   assign level     = level_ff;
   assign pop       = out_valid && out_ready;

   always_comb begin
      wr_ptr_in = wr_ptr_ff + PTR_W'(push.count);
      rd_ptr_in = rd_ptr_ff + PTR_W'(pop);
      level_in  = level_ff + LVL_W'(push.count) - LVL_W'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         level_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         level_ff  <= level_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push.count != 2'd0) mem_ff[wr_ptr_ff] <= push.first;
      if (push.count == 2'd2) mem_ff[wr_ptr_ff + PTR_W'(1)] <= push.second;
   end

endmodule

[rtl/delimiter_frame_extractor.sv]
// ----------------------------------------------------------------------------
// delimiter_frame_extractor
// Byte-stream deframer: hunts for lead+start, emits body bytes with their
// index, closes on lead+stop with a length/overflow result.
// ----------------------------------------------------------------------------
//  channel  dir  handshake          payload
//  req_     in   tvalid/tready      tdata[7:0] rx_byte
//  rsp_     out  tvalid/tready      tdata[7:0] out_byte, [19:8] position,
//                                   [20] overflowed; tlast frame_end
//  csr_     in   we (no wait)       index 0 lead, 1 start, 2 stop; wdata
//
//  One byte per cycle while the result queue has room; a byte goes input
//  register -> deframer -> result queue.
//  A held lead followed by a body byte gives two results; the 4-entry result
//  queue absorbs that, and input stalls only while it holds more than two.
//  Sync active-high reset clears phase, count, queue; CSRs load defaults.
// ----------------------------------------------------------------------------
module delimiter_frame_extractor import dfe_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   // input stream
   input  logic                 req_tvalid,
   output logic                 req_tready,
   input  logic [7:0]           req_tdata,   // [7:0] rx_byte
   // result stream
   output logic                 rsp_tvalid,
   input  logic                 rsp_tready,
   output logic [23:0]          rsp_tdata,   // [7:0] out_byte, [19:8] position,
                                             // [20] overflowed, [23:21] zero
   output logic                 rsp_tlast,   // frame_end
   // configuration writes
   input  logic                 csr_we,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [BYTE_W-1:0]    csr_wdata
);

   logic              in_valid_ff, in_valid_in;
   logic [BYTE_W-1:0] in_byte_ff;
   logic              fire;
   logic [LVL_W-1:0]  level;
   dfe_push_type      push;
   dfe_result_type    head;

   // process the held byte only when the queue has room for two results
   assign fire       = in_valid_ff && (level <= LVL_W'(FIFO_DEPTH - 2));
   assign req_tready = !in_valid_ff || fire;

   always_comb begin
      in_valid_in = in_valid_ff;
      if (fire) in_valid_in = 1'b0;
      if (req_tvalid && req_tready) in_valid_in = 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
   end

   // input register (payload, no reset)
   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) in_byte_ff <= req_tdata[BYTE_W-1:0];
   end

   dfe_core u_core (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .fire      (fire),
      .rx_byte   (in_byte_ff),
      .push      (push)
   );

   dfe_fifo u_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .out_data  (head),
      .level     (level)
   );

   assign rsp_tdata = {3'b000, head.overflowed, head.position, head.out_byte};
   assign rsp_tlast = head.frame_end;

`ifndef SYNTHESIS
   // queue never overfills: the room check must hold off the deframer
   a_level_bound: assert property (@(posedge clock) disable iff (reset)
      level <= LVL_W'(FIFO_DEPTH))
      else $error("result queue overfilled");

   // a frame-end transaction carries a zero byte
   a_end_byte_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tlast |-> rsp_tdata[7:0] == 8'h00)
      else $error("frame end with non-zero byte");

   // a body byte never reports overflow
   a_body_no_ovf: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tlast |-> !rsp_tdata[20])
      else $error("overflow flag on body byte");
`endif

endmodule
